// File: rtl/core/srtp_pkg.sv
package srtp_pkg;

  // Parser states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WRESP = 4'd1;
  localparam logic [3:0] ST_BTNR  = 4'd2;
  localparam logic [3:0] ST_BTNP  = 4'd3;
  localparam logic [3:0] ST_WLAST = 4'd4;
  localparam logic [3:0] ST_DATA  = 4'd5;
  localparam logic [3:0] ST_DROP  = 4'd6;
  localparam logic [3:0] ST_KONF  = 4'd7;
  localparam logic [3:0] ST_KONFN = 4'd8;
  localparam logic [3:0] ST_VERB  = 4'd9;
  localparam logic [3:0] ST_SMODE = 4'd10;
  localparam logic [3:0] ST_VERS  = 4'd11;
  // A rule whose state field holds this code applies in every state.
  localparam logic [3:0] ST_ANY   = 4'd15;

  // Action codes.
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_RELEASED = 3'd1;
  localparam logic [2:0] ACT_PRESSED  = 3'd2;
  localparam logic [2:0] ACT_DBEGIN   = 3'd3;
  localparam logic [2:0] ACT_DDIGIT   = 3'd4;
  localparam logic [2:0] ACT_DEND     = 3'd5;
  localparam logic [2:0] ACT_CFGNUM   = 3'd6;
  localparam logic [2:0] ACT_VERSION  = 3'd7;

  // Length of the word "ONFIGURATION" that follows the 'K' reply.
  localparam logic [7:0] KONF_WORD_LEN = 8'd12;
  localparam logic [3:0] OFFSET_MAX    = 4'd15;

  typedef struct packed {
    logic [3:0] cur;
    logic       seq;  // 1: match on the offset range, 0: match on the byte range
    logic [7:0] lo;
    logic [7:0] hi;
    logic [2:0] act;
    logic [3:0] nxt;
  } rule_t;

  localparam int RULE_COUNT = 44;

  // Priority order: the lowest index that matches wins.
  localparam rule_t RULES [RULE_COUNT] = '{
    '{ST_IDLE,  1'b0, "F", "F", ACT_NONE,     ST_BTNR },
    '{ST_IDLE,  1'b0, "N", "N", ACT_NONE,     ST_BTNP },
    '{ST_WRESP, 1'b0, "F", "F", ACT_NONE,     ST_BTNR },
    '{ST_WRESP, 1'b0, "N", "N", ACT_NONE,     ST_BTNP },
    '{ST_BTNR,  1'b0, "*", "*", ACT_RELEASED, ST_IDLE },
    '{ST_BTNP,  1'b0, "*", "*", ACT_PRESSED,  ST_IDLE },
    '{ST_WLAST, 1'b0, "*", "*", ACT_NONE,     ST_IDLE },
    '{ST_WRESP, 1'b0, "h", "h", ACT_NONE,     ST_WLAST},
    '{ST_IDLE,  1'b0, "h", "h", ACT_NONE,     ST_WLAST},
    '{ST_WRESP, 1'b0, "l", "l", ACT_NONE,     ST_WLAST},
    '{ST_IDLE,  1'b0, "l", "l", ACT_NONE,     ST_WLAST},
    '{ST_DATA,  1'b0, "0", "9", ACT_DDIGIT,   ST_DATA },
    '{ST_DATA,  1'b0, "A", "F", ACT_DDIGIT,   ST_DATA },
    '{ST_DATA,  1'b0, "*", "*", ACT_DEND,     ST_IDLE },
    '{ST_WRESP, 1'b0, "A", "A", ACT_NONE,     ST_DROP },
    '{ST_IDLE,  1'b0, "A", "A", ACT_NONE,     ST_DROP },
    '{ST_WRESP, 1'b0, "D", "D", ACT_NONE,     ST_DROP },
    '{ST_IDLE,  1'b0, "D", "D", ACT_NONE,     ST_DROP },
    '{ST_DROP,  1'b0, "0", "9", ACT_NONE,     ST_DROP },
    '{ST_DROP,  1'b0, "A", "F", ACT_NONE,     ST_DROP },
    '{ST_DROP,  1'b0, "*", "*", ACT_NONE,     ST_IDLE },
    '{ST_WRESP, 1'b0, "S", "S", ACT_DBEGIN,   ST_DATA },
    '{ST_WRESP, 1'b0, "R", "R", ACT_DBEGIN,   ST_DATA },
    '{ST_WRESP, 1'b0, "r", "r", ACT_DBEGIN,   ST_DATA },
    '{ST_IDLE,  1'b0, "r", "r", ACT_DBEGIN,   ST_DATA },
    '{ST_WRESP, 1'b0, "I", "I", ACT_DBEGIN,   ST_DATA },
    '{ST_WRESP, 1'b0, "i", "i", ACT_DBEGIN,   ST_DATA },
    '{ST_IDLE,  1'b0, "i", "i", ACT_DBEGIN,   ST_DATA },
    '{ST_WRESP, 1'b0, "E", "E", ACT_NONE,     ST_WLAST},
    '{ST_WRESP, 1'b0, "K", "K", ACT_NONE,     ST_KONF },
    '{ST_KONF,  1'b1, 8'd0, KONF_WORD_LEN, ACT_NONE, ST_KONF},
    '{ST_KONF,  1'b0, "_", "_", ACT_NONE,     ST_KONFN},
    '{ST_KONFN, 1'b0, "1", "8", ACT_CFGNUM,   ST_WLAST},
    '{ST_WRESP, 1'b0, "Q", "Q", ACT_NONE,     ST_WLAST},
    '{ST_WRESP, 1'b0, "V", "V", ACT_NONE,     ST_VERB },
    '{ST_WRESP, 1'b0, "M", "M", ACT_NONE,     ST_SMODE},
    '{ST_VERB,  1'b0, "0", "1", ACT_NONE,     ST_WLAST},
    '{ST_SMODE, 1'b0, "0", "1", ACT_NONE,     ST_WLAST},
    '{ST_WRESP, 1'b0, "?", "?", ACT_VERSION,  ST_VERS },
    '{ST_VERS,  1'b0, ".", "z", ACT_VERSION,  ST_VERS },
    '{ST_VERS,  1'b0, "*", "*", ACT_VERSION,  ST_IDLE },
    '{ST_IDLE,  1'b0, "0", "9", ACT_NONE,     ST_IDLE },
    '{ST_IDLE,  1'b0, "*", "*", ACT_NONE,     ST_IDLE },
    '{ST_ANY,   1'b0, "!", "!", ACT_NONE,     ST_WLAST}
  };

endpackage

// File: rtl/core/serial_response_token_parser_unit.sv
// A result word is registered and is valid in the cycle after its input word is taken.
// Throughput: one word per cycle while out_ready is high, set by the single result
// register; a new word is taken while the held result is being drained.
// Reset (rst, synchronous, active high) puts the parser in the idle state, clears the
// offset counter and empties the result register.
module serial_response_token_parser_unit
  import srtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [7:0] rx_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       accepted,
  output logic [2:0] action,
  output logic [7:0] action_char,
  output logic [3:0] parser_state_out
);

  // Parser state and the count of matched bytes that kept the state since it was entered.
  logic [3:0] parser_state;
  logic [3:0] offset_count;
  logic [3:0] parser_state_next;
  logic [3:0] offset_count_next;

  // Result of the rule search for the byte at the input.
  logic       hit;
  logic [2:0] hit_act;
  logic [3:0] hit_nxt;

  logic       accepted_next;
  logic [2:0] action_next;
  logic [7:0] action_char_next;

  logic       take;

  // The result register is free when empty or when its word leaves in this cycle.
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Every rule is matched in parallel; walking the table from the back lets the
  // earliest matching rule overwrite any later one, which gives table priority.
  always_comb begin
    hit     = 1'b0;
    hit_act = ACT_NONE;
    hit_nxt = parser_state;
    for (int i = RULE_COUNT - 1; i >= 0; i--) begin
      if ((RULES[i].cur == parser_state) || (RULES[i].cur == ST_ANY)) begin
        if (RULES[i].seq) begin
          // Offset-range rule: the byte value itself is not looked at.
          if (({4'd0, offset_count} >= RULES[i].lo) &&
              ({4'd0, offset_count} < RULES[i].hi)) begin
            hit     = 1'b1;
            hit_act = RULES[i].act;
            hit_nxt = RULES[i].nxt;
          end
        end else if ((rx_char >= RULES[i].lo) && (rx_char <= RULES[i].hi)) begin
          hit     = 1'b1;
          hit_act = RULES[i].act;
          hit_nxt = RULES[i].nxt;
        end
      end
    end
  end

  // Next state and result word for the word at the input.
  always_comb begin
    parser_state_next = parser_state;
    offset_count_next = offset_count;
    accepted_next     = 1'b0;
    action_next       = ACT_NONE;
    action_char_next  = 8'd0;
    if (operation) begin
      // A command went out: wait for its reply.
      parser_state_next = ST_WRESP;
      offset_count_next = 4'd0;
    end else if (hit) begin
      accepted_next = 1'b1;
      action_next   = hit_act;
      if (hit_act != ACT_NONE) begin
        action_char_next = rx_char;
      end
      if (hit_nxt != parser_state) begin
        // A change of state restarts the offset.
        parser_state_next = hit_nxt;
        offset_count_next = 4'd0;
      end else if (offset_count != OFFSET_MAX) begin
        offset_count_next = offset_count + 4'd1;
      end
    end
    // With no matching rule the state and offset stay as they are.
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parser_state <= ST_IDLE;
      offset_count <= 4'd0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        parser_state <= parser_state_next;
        offset_count <= offset_count_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; it only changes when a new word is taken.
  always_ff @(posedge clk) begin
    if (take) begin
      accepted         <= accepted_next;
      action           <= action_next;
      action_char      <= action_char_next;
      parser_state_out <= parser_state_next;
    end
  end

endmodule
